// ===== rtl/core/bhpq_pkg.sv =====
package bhpq_pkg;

  localparam int HEAP_DEPTH     = 64;
  localparam int HEAP_KEY_WIDTH = 32;

  // command codes
  localparam logic [2:0] CMD_PUSH    = 3'd0;
  localparam logic [2:0] CMD_POP     = 3'd1;
  localparam logic [2:0] CMD_UPDATE  = 3'd2;
  localparam logic [2:0] CMD_APPEND  = 3'd3;
  localparam logic [2:0] CMD_HEAPIFY = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // register indexes
  localparam int REG_ORDER_MODE = 0;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] key_in;
    logic [5:0]  entry_index;
  } in_word_t;

  typedef struct packed {
    logic [31:0] key_out;
    logic [1:0]  status;
    logic [6:0]  count_out;
    logic [31:0] top_key;
  } out_word_t;

  typedef enum logic [4:0] {
    DP_IDLE,
    DP_LOAD,
    DP_FAIL,
    DP_APPEND,
    DP_PUSH,
    DP_POP,
    DP_POP_KEY,
    DP_UPD,
    DP_HF,
    DP_HF_LOAD,
    DP_HF_KEY,
    DP_HF_NEXT,
    DP_SD_READ,
    DP_SD_CMP,
    DP_SU_READ,
    DP_SU_CMP,
    DP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd_code;
    logic       count_zero;
    logic       full;
    logic       idx_bad;
    logic       lt2;
    logic       last_zero;
    logic       left_ge;
    logic       go_down;
    logic       pos_zero;
    logic       go_up;
    logic       moved;
    logic       hi_zero;
  } dp_flags_t;

endpackage

// ===== rtl/core/bhpq_dp.sv =====
module bhpq_dp
  import bhpq_pkg::*;
#(
  parameter int DEPTH     = HEAP_DEPTH,
  parameter int KEY_WIDTH = HEAP_KEY_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      order_mode,
  input  in_word_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_flags_t flags,
  output out_word_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + 1;

  typedef logic [KEY_WIDTH-1:0] key_t;

  key_t          mem [DEPTH];
  key_t          rd_a;
  key_t          rd_b;
  key_t          root;

  logic [2:0]    cmd_code;
  key_t          key;
  logic [5:0]    idx_in;
  logic [AW-1:0] pos;
  logic [CW-1:0] lim;
  logic [CW-1:0] count;
  logic [AW-1:0] hi;
  logic          moved;
  key_t          res_key;
  logic [1:0]    res_status;

  logic [CW-1:0] last;
  logic [XW-1:0] left;
  logic [XW-1:0] right;
  logic          left_ge;
  logic          right_lt;
  logic          pick_right;
  key_t          ckey;
  logic [AW-1:0] cidx;
  logic [AW-1:0] parent;
  logic          go_down;
  logic          go_up;
  logic          pos_zero;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  key_t          wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;

  // true if a must sit strictly above b
  function automatic logic ahead(input logic mode, input key_t a, input key_t b);
    ahead = mode ? (a > b) : (a < b);
  endfunction

  assign last       = count - CW'(1);
  assign left       = XW'({pos, 1'b1});
  assign right      = left + XW'(1);
  assign left_ge    = left >= XW'(lim);
  assign right_lt   = right < XW'(lim);
  assign pick_right = right_lt && ahead(order_mode, rd_b, rd_a);
  assign ckey       = pick_right ? rd_b : rd_a;
  assign cidx       = pick_right ? right[AW-1:0] : left[AW-1:0];
  assign parent     = AW'((pos - AW'(1)) >> 1);
  assign go_down    = ahead(order_mode, ckey, key);
  assign go_up      = ahead(order_mode, key, rd_a);
  assign pos_zero   = (pos == '0);

  assign flags.cmd_code   = cmd_code;
  assign flags.count_zero = (count == '0);
  assign flags.full       = (count == CW'(DEPTH));
  assign flags.idx_bad    = (32'(idx_in) >= 32'(count));
  assign flags.lt2        = (count < CW'(2));
  assign flags.last_zero  = (count == CW'(1));
  assign flags.left_ge    = left_ge;
  assign flags.go_down    = go_down;
  assign flags.pos_zero   = pos_zero;
  assign flags.go_up      = go_up;
  assign flags.moved      = moved;
  assign flags.hi_zero    = (hi == '0);

  // memory port selection
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = pos;
    wr_data   = key;
    rd_en     = 1'b0;
    rd_addr_a = pos;
    rd_addr_b = pos;
    case (cmd.op)
      DP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = count[AW-1:0];
      end
      DP_POP: begin
        rd_en     = 1'b1;
        rd_addr_a = last[AW-1:0];
      end
      DP_HF_LOAD: begin
        rd_en     = 1'b1;
        rd_addr_a = hi;
      end
      DP_SD_READ: begin
        if (left_ge) begin
          wr_en = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr_a = left[AW-1:0];
          rd_addr_b = right_lt ? right[AW-1:0] : left[AW-1:0];
        end
      end
      DP_SD_CMP: begin
        wr_en = 1'b1;
        if (go_down) begin
          wr_data = ckey;
        end
      end
      DP_SU_READ: begin
        if (pos_zero) begin
          wr_en = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr_a = parent;
        end
      end
      DP_SU_CMP: begin
        wr_en = 1'b1;
        if (go_up) begin
          wr_data = rd_a;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[rd_addr_b];
    end
  end

  // shadow copy of the root entry
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == '0) begin
      root <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.op)
        DP_APPEND, DP_PUSH: count <= count + CW'(1);
        DP_POP:             count <= last;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        cmd_code   <= in_data.command;
        key        <= KEY_WIDTH'(in_data.key_in);
        idx_in     <= in_data.entry_index;
        res_key    <= '0;
        res_status <= ST_OK;
        moved      <= 1'b0;
      end
      DP_FAIL: res_status <= cmd.status;
      DP_APPEND: res_key <= key;
      DP_PUSH: begin
        pos     <= count[AW-1:0];
        res_key <= key;
      end
      DP_POP: begin
        res_key <= root;
        lim     <= last;
        pos     <= '0;
      end
      DP_POP_KEY: key <= rd_a;
      DP_UPD: begin
        pos     <= AW'(idx_in);
        lim     <= count;
        res_key <= key;
      end
      DP_HF: begin
        lim <= count;
        hi  <= AW'(count >> 1) - AW'(1);
      end
      DP_HF_LOAD: pos <= hi;
      DP_HF_KEY: key <= rd_a;
      DP_HF_NEXT: hi <= hi - AW'(1);
      DP_SD_CMP: begin
        if (go_down) begin
          pos   <= cidx;
          moved <= 1'b1;
        end
      end
      DP_SU_CMP: begin
        if (go_up) begin
          pos <= parent;
        end
      end
      DP_DONE: begin
        out_data.key_out   <= 32'(res_key);
        out_data.status    <= res_status;
        out_data.count_out <= 7'(count);
        out_data.top_key   <= (count != '0) ? 32'(root) : 32'd0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/bhpq_ctrl.sv =====
module bhpq_ctrl
  import bhpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_flags_t flags,
  output dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_POP_KEY,
    S_HF_LOAD,
    S_HF_KEY,
    S_HF_NEXT,
    S_SD_READ,
    S_SD_CMP,
    S_SU_READ,
    S_SU_CMP,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  state_t sd_exit;

  assign in_ready = (state == S_IDLE);

  // where to go once sift-down settles
  always_comb begin
    if (flags.cmd_code == CMD_UPDATE && !flags.moved) begin
      sd_exit = S_SU_READ;
    end else if (flags.cmd_code == CMD_HEAPIFY && !flags.hi_zero) begin
      sd_exit = S_HF_NEXT;
    end else begin
      sd_exit = S_FINISH;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = DP_IDLE;
    cmd.status     = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        case (flags.cmd_code)
          CMD_PUSH: begin
            if (flags.full) begin
              cmd.op     = DP_FAIL;
              cmd.status = ST_FULL;
              state_next = S_FINISH;
            end else begin
              cmd.op     = DP_PUSH;
              state_next = S_SU_READ;
            end
          end
          CMD_APPEND: begin
            if (flags.full) begin
              cmd.op     = DP_FAIL;
              cmd.status = ST_FULL;
            end else begin
              cmd.op = DP_APPEND;
            end
            state_next = S_FINISH;
          end
          CMD_POP: begin
            if (flags.count_zero) begin
              cmd.op     = DP_FAIL;
              cmd.status = ST_EMPTY;
              state_next = S_FINISH;
            end else begin
              cmd.op     = DP_POP;
              state_next = flags.last_zero ? S_FINISH : S_POP_KEY;
            end
          end
          CMD_UPDATE: begin
            if (flags.idx_bad) begin
              cmd.op     = DP_FAIL;
              cmd.status = ST_RANGE;
              state_next = S_FINISH;
            end else begin
              cmd.op     = DP_UPD;
              state_next = S_SD_READ;
            end
          end
          CMD_HEAPIFY: begin
            if (flags.lt2) begin
              state_next = S_FINISH;
            end else begin
              cmd.op     = DP_HF;
              state_next = S_HF_LOAD;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_POP_KEY: begin
        cmd.op     = DP_POP_KEY;
        state_next = S_SD_READ;
      end
      S_HF_LOAD: begin
        cmd.op     = DP_HF_LOAD;
        state_next = S_HF_KEY;
      end
      S_HF_KEY: begin
        cmd.op     = DP_HF_KEY;
        state_next = S_SD_READ;
      end
      S_HF_NEXT: begin
        cmd.op     = DP_HF_NEXT;
        state_next = S_HF_LOAD;
      end
      S_SD_READ: begin
        cmd.op     = DP_SD_READ;
        state_next = flags.left_ge ? sd_exit : S_SD_CMP;
      end
      S_SD_CMP: begin
        cmd.op     = DP_SD_CMP;
        state_next = flags.go_down ? S_SD_READ : sd_exit;
      end
      S_SU_READ: begin
        cmd.op     = DP_SU_READ;
        state_next = flags.pos_zero ? S_FINISH : S_SU_CMP;
      end
      S_SU_CMP: begin
        cmd.op     = DP_SU_CMP;
        state_next = flags.go_up ? S_SU_READ : S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.op         = DP_DONE;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/core/binary_heap_priority_queue_unit.sv =====
// Append, rejected and no-op commands pass from accept through a check state to the result; push, pop and
//   update also walk the heap, with a read and then a compare at each level walked.
// Heapify runs one sift-down per parent, from the last parent back to the root.
// One word is in work at a time; the single-write, dual-read key memory sets the pace.
// Reset (synchronous, rst high) empties the heap and sets min order; keys are not cleared.
module binary_heap_priority_queue_unit
  import bhpq_pkg::*;
#(
  parameter int DEPTH     = HEAP_DEPTH,
  parameter int KEY_WIDTH = HEAP_KEY_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic      order_mode;
  dp_cmd_t   cmd;
  dp_flags_t flags;
  logic      reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (32'(paddr[2]) == REG_ORDER_MODE);
  assign prdata  = reg_hit ? {31'd0, order_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      order_mode <= pwdata[0];
    end
  end

  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  bhpq_dp #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .order_mode (order_mode),
    .in_data    (in_data),
    .cmd        (cmd),
    .flags      (flags),
    .out_data   (out_data)
  );

endmodule

// ===== tb/tb_binary_heap_priority_queue_unit.sv =====
module tb_binary_heap_priority_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bhpq_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [31:0] KEY_ALL_ONES = 32'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  binary_heap_priority_queue_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the heap
  logic [31:0] heap_keys [HEAP_DEPTH];
  int          heap_len = 0;
  bit          max_first = 1'b0;

  in_word_t  pending_words [$];
  out_word_t expected_results [$];
  int        planned_len = 0;
  int        sent_count = 0;
  int        taken_count = 0;
  int        send_gap = 0;
  int        send_calm = 0;
  int        recv_stall = 0;
  int        recv_calm = 0;
  int        error_count = 0;
  int        cycle_count = 0;

  function automatic bit ranks_above(logic [31:0] a, logic [31:0] b);
    return max_first ? (a > b) : (a < b);
  endfunction

  function automatic void swap_keys(int x, int y);
    logic [31:0] t;
    t = heap_keys[x];
    heap_keys[x] = heap_keys[y];
    heap_keys[y] = t;
  endfunction

  function automatic void bubble_up(int pos);
    int parent;
    while (pos != 0) begin
      parent = (pos - 1) / 2;
      if (!ranks_above(heap_keys[pos], heap_keys[parent])) break;
      swap_keys(parent, pos);
      pos = parent;
    end
  endfunction

  // true if the entry moved down; left child wins unless right is strictly ahead
  function automatic bit bubble_down(int start, int n);
    int pos;
    int child;
    pos = start;
    while (1) begin
      child = 2 * pos + 1;
      if (child >= n) break;
      if (child + 1 < n && ranks_above(heap_keys[child + 1], heap_keys[child]))
        child = child + 1;
      if (!ranks_above(heap_keys[child], heap_keys[pos])) break;
      swap_keys(pos, child);
      pos = child;
    end
    return pos > start;
  endfunction

  function automatic out_word_t apply_command(in_word_t w);
    out_word_t r;
    int        last;
    int        idx;
    r = '0;
    r.status = ST_OK;
    idx = w.entry_index;
    case (w.command)
      CMD_PUSH, CMD_APPEND: begin
        if (heap_len >= HEAP_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          heap_keys[heap_len] = w.key_in;
          heap_len++;
          if (w.command == CMD_PUSH) bubble_up(heap_len - 1);
          r.key_out = w.key_in;
        end
      end
      CMD_POP: begin
        if (heap_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          last = heap_len - 1;
          swap_keys(0, last);
          void'(bubble_down(0, last));
          r.key_out = heap_keys[last];
          heap_len = last;
        end
      end
      CMD_UPDATE: begin
        if (idx >= heap_len) begin
          r.status = ST_RANGE;
        end else begin
          heap_keys[idx] = w.key_in;
          if (!bubble_down(idx, heap_len)) bubble_up(idx);
          r.key_out = w.key_in;
        end
      end
      CMD_HEAPIFY: begin
        if (heap_len >= 2) begin
          for (int i = heap_len / 2 - 1; i >= 0; i--) void'(bubble_down(i, heap_len));
        end
      end
      default: begin
      end
    endcase
    r.count_out = 7'(heap_len);
    r.top_key = (heap_len > 0) ? heap_keys[0] : '0;
    return r;
  endfunction

  // mostly back to back or short, now and then long, with calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(15, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    error_count++;
  endtask

  function automatic void plan(logic [2:0] cmd, logic [31:0] key, logic [5:0] idx);
    in_word_t w;
    w.command = cmd;
    w.key_in = key;
    w.entry_index = idx;
    pending_words.push_back(w);
    if ((cmd == CMD_PUSH || cmd == CMD_APPEND) && planned_len < HEAP_DEPTH) planned_len++;
    if (cmd == CMD_POP && planned_len > 0) planned_len--;
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return KEY_ALL_ONES;
      2, 3, 4: return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // input side: hold the word until taken, then idle or advance
  always @(negedge clk) begin
    if (!(in_valid && sent_count != taken_count)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_words.size() != 0) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
        sent_count++;
        send_gap = pick_gap(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (!rst && in_valid && in_ready) begin
      expected_results.push_back(apply_command(in_data));
      taken_count++;
    end
  end

  always @(negedge clk) begin
    if (recv_stall > 0) begin
      out_ready <= 1'b0;
      recv_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.key_out !== want.key_out)
          flag_mismatch("key_out", want.key_out, out_data.key_out);
        if (out_data.status !== want.status)
          flag_mismatch("status", 32'(want.status), 32'(out_data.status));
        if (out_data.count_out !== want.count_out)
          flag_mismatch("count_out", 32'(want.count_out), 32'(out_data.count_out));
        if (out_data.top_key !== want.top_key)
          flag_mismatch("top_key", want.top_key, out_data.top_key);
      end
      recv_stall = pick_gap(recv_calm);
    end
  end

  task automatic wait_idle();
    while (pending_words.size() != 0 || sent_count != taken_count ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the order register, then read it back
  task automatic set_order(bit mode);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(REG_ORDER_MODE * 4);
    pwdata <= 32'(mode);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    max_first = mode;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(mode)) flag_mismatch("order_mode readback", 32'(mode), prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random(int n_items);
    bit          filling;
    int          done;
    int          r;
    logic [5:0]  idx;
    logic [2:0]  cmd;
    filling = 1'b1;
    done = 0;
    while (done < n_items) begin
      if (filling && planned_len == HEAP_DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (!filling && planned_len == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      if ($urandom_range(0, 39) == 0) filling = !filling;
      r = $urandom_range(0, 99);
      if (filling) begin
        if (r < 55) cmd = CMD_PUSH;
        else if (r < 70) cmd = CMD_APPEND;
        else if (r < 78) cmd = CMD_POP;
        else if (r < 93) cmd = CMD_UPDATE;
        else if (r < 97) cmd = CMD_HEAPIFY;
        else cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end else begin
        if (r < 20) cmd = CMD_PUSH;
        else if (r < 25) cmd = CMD_APPEND;
        else if (r < 72) cmd = CMD_POP;
        else if (r < 90) cmd = CMD_UPDATE;
        else if (r < 96) cmd = CMD_HEAPIFY;
        else cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end
      // mostly in range; some land past the end
      if (planned_len > 0 && $urandom_range(0, 99) < 85)
        idx = 6'($urandom_range(0, planned_len - 1));
      else
        idx = 6'($urandom_range(0, HEAP_DEPTH - 1));
      plan(cmd, pick_key(), idx);
      if (cmd < CMD_SPARE_FIRST) done++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_order(1'b0);

    // empty heap cases and the unused codes
    plan(CMD_POP, '0, '0);
    plan(CMD_HEAPIFY, '0, '0);
    plan(CMD_UPDATE, 32'd7, '0);
    plan(CMD_SPARE_FIRST, KEY_ALL_ONES, 6'h3F);
    plan(3'(CMD_SPARE_FIRST + 1), 32'd1, 6'h15);
    plan(CMD_SPARE_LAST, 32'd2, 6'h2A);
    // extremes and equal keys
    plan(CMD_PUSH, KEY_ALL_ONES, '0);
    plan(CMD_PUSH, '0, '0);
    plan(CMD_PUSH, 32'd5, '0);
    plan(CMD_PUSH, 32'd5, '0);
    plan(CMD_APPEND, KEY_ALL_ONES, '0);
    plan(CMD_APPEND, 32'd1, '0);
    plan(CMD_APPEND, 32'd3, '0);
    plan(CMD_UPDATE, '0, 6'd6);
    plan(CMD_UPDATE, KEY_ALL_ONES, 6'd0);
    plan(CMD_UPDATE, 32'd9, 6'h3F);
    plan(CMD_UPDATE, 32'd5, 6'd2);
    plan(CMD_HEAPIFY, '0, '0);
    plan(CMD_POP, '0, '0);
    plan(CMD_POP, '0, '0);
    plan(CMD_POP, '0, '0);
    plan(CMD_PUSH, 32'hAAAA_AAAA, 6'h2A);
    plan(CMD_PUSH, 32'h5555_5555, 6'h15);
    wait_idle();

    run_random(150);
    wait_idle();
    // flip order with entries still held; heapify restores it
    set_order(1'b1);
    plan(CMD_HEAPIFY, '0, '0);
    run_random(150);
    wait_idle();
    set_order(1'b0);
    plan(CMD_HEAPIFY, '0, '0);
    run_random(150);
    wait_idle();

    repeat (30) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
